/* design/divergence_free_mode_projection_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the divergence-free mode projection block
// Clocked, reset-qualified property templates used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef DIVERGENCE_FREE_MODE_PROJECTION_ASSERT_SVH
`define DIVERGENCE_FREE_MODE_PROJECTION_ASSERT_SVH

// whenever ante holds, cons must hold in the same cycle
`define DFMP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold
`define DFMP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/dfmp_pkg.sv */
// ----------------------------------------------------------------------------
// dfmp_pkg
// Widths, latencies and shared types of the divergence-free mode projection.
// ----------------------------------------------------------------------------
package dfmp_pkg;

    localparam int MAX_WAVE   = 12;
    localparam int WAVE_W     = 5;
    localparam int VEC_W      = 32;
    localparam int NUM_PARTS  = 2;

    // |k|^2 never exceeds three times the squared clamp limit
    localparam int NORM_W     = $clog2(3 * MAX_WAVE * MAX_WAVE + 1);
    localparam int PROD_W     = VEC_W + WAVE_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int MAG_W      = DOT_W - 1;

    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = (MAG_W + STEP_BITS - 1) / STEP_BITS;
    localparam int QUO_W      = DIV_STAGES * STEP_BITS;

    localparam int CPROD_W    = WAVE_W + QUO_W + 1;
    localparam int DIFF_W     = CPROD_W + 1;

    localparam int LANE_LAT   = DIV_STAGES + 5;
    localparam int TOTAL_LAT  = LANE_LAT + 2;

    typedef logic signed [WAVE_W-1:0] wave_t;
    typedef wave_t                    wave3_t [0:2];
    typedef logic [NORM_W-1:0]        norm_t;
    typedef logic signed [VEC_W-1:0]  comp_t;
    typedef comp_t                    comp3_t [0:2];

    typedef struct packed {
        logic valid;
        logic zero;
    } ctrl_t;

    localparam wave_t WAVE_HI = wave_t'(MAX_WAVE);
    localparam wave_t WAVE_LO = wave_t'(-MAX_WAVE);

endpackage

/* design/dfmp_lane.sv */
// ----------------------------------------------------------------------------
// dfmp_lane
// One part (real or imaginary) of the projection: dot product, pipelined
// radix-2 division by |k|^2, and the saturated correction v - k*c.
// ----------------------------------------------------------------------------
module dfmp_lane
(
    input  logic             clk,
    input  dfmp_pkg::wave3_t k,
    input  dfmp_pkg::norm_t  n,
    input  dfmp_pkg::comp3_t v,
    output dfmp_pkg::comp3_t proj,
    output dfmp_pkg::comp3_t orig
);
    import dfmp_pkg::*;

    typedef struct packed {
        logic [2:0][WAVE_W-1:0] k;
        logic [2:0][VEC_W-1:0]  v;
        norm_t                  n;
    } carry_t;

    typedef logic [QUO_W-1:0] quo_t;

    carry_t                    carry_in;
    carry_t                    carry_reg [0:LANE_LAT-1];

    logic signed [PROD_W-1:0]  prod_reg  [0:2];
    logic signed [PROD_W-1:0]  prod_next [0:2];
    logic signed [DOT_W-1:0]   dot_reg;
    logic signed [DOT_W-1:0]   dot_next;
    logic [MAG_W-1:0]          mag_next;

    // index 0 holds the magnitude, index s+1 the output of divider stage s
    norm_t                     rem_reg   [0:DIV_STAGES];
    norm_t                     rem_next  [0:DIV_STAGES-1];
    quo_t                      dq_reg    [0:DIV_STAGES];
    quo_t                      dq_next   [0:DIV_STAGES-1];
    logic                      neg_reg   [0:DIV_STAGES];

    logic signed [CPROD_W-1:0] cprod_reg  [0:2];
    logic signed [CPROD_W-1:0] cprod_next [0:2];
    logic                      cneg_reg;
    comp3_t                    proj_reg;
    comp3_t                    proj_next;

    function automatic comp_t sat(input logic signed [DIFF_W-1:0] d);
        if (&d[DIFF_W-1:VEC_W-1] || ~|d[DIFF_W-1:VEC_W-1])
        begin
            return d[VEC_W-1:0];
        end
        else
        begin
            return {d[DIFF_W-1], {(VEC_W-1){~d[DIFF_W-1]}}};
        end
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            carry_in.k[i] = k[i];
            carry_in.v[i] = v[i];
            prod_next[i]  = PROD_W'(k[i]) * PROD_W'(v[i]);
        end
        carry_in.n = n;
    end

    assign dot_next = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
    assign mag_next = dot_reg[DOT_W-1] ? MAG_W'(-dot_reg) : MAG_W'(dot_reg);

    // restoring division, STEP_BITS quotient bits per stage; the dividend
    // shifts out of the top of dq while quotient bits shift in at the bottom
    always_comb
    begin
        logic [NORM_W:0] trial;
        norm_t           r;
        quo_t            q;
        norm_t           dvs;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            r   = rem_reg[s];
            q   = dq_reg[s];
            dvs = carry_reg[2+s].n;
            for (int j = 0; j < STEP_BITS; j++)
            begin
                trial = {r, q[QUO_W-1]};
                q     = {q[QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs})
                begin
                    r    = NORM_W'(trial - {1'b0, dvs});
                    q[0] = 1'b1;
                end
                else
                begin
                    r = trial[NORM_W-1:0];
                end
            end
            rem_next[s] = r;
            dq_next[s]  = q;
        end
    end

    // apply the sign of the dot product to the add/subtract instead of c
    always_comb
    begin
        logic signed [DIFF_W-1:0] vx;
        logic signed [DIFF_W-1:0] px;
        for (int i = 0; i < 3; i++)
        begin
            cprod_next[i] = CPROD_W'($signed(carry_reg[2+DIV_STAGES].k[i]))
                          * $signed(CPROD_W'({1'b0, dq_reg[DIV_STAGES]}));
            vx = DIFF_W'($signed(carry_reg[3+DIV_STAGES].v[i]));
            px = DIFF_W'(cprod_reg[i]);
            proj_next[i] = sat(cneg_reg ? vx + px : vx - px);
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg[0] <= carry_in;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            carry_reg[i] <= carry_reg[i-1];
        end
        prod_reg   <= prod_next;
        dot_reg    <= dot_next;
        rem_reg[0] <= '0;
        dq_reg[0]  <= QUO_W'(mag_next);
        neg_reg[0] <= dot_reg[DOT_W-1];
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s+1] <= rem_next[s];
            dq_reg[s+1]  <= dq_next[s];
            neg_reg[s+1] <= neg_reg[s];
        end
        cprod_reg <= cprod_next;
        cneg_reg  <= neg_reg[DIV_STAGES];
        proj_reg  <= proj_next;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            orig[i] = carry_reg[LANE_LAT-1].v[i];
        end
    end

    assign proj = proj_reg;

endmodule

/* design/dfmp_merge.sv */
// ----------------------------------------------------------------------------
// dfmp_merge
// Joins the real and imaginary lanes into one result and raises the strobe;
// a zero wave vector takes the original vector instead of the projection.
// ----------------------------------------------------------------------------
module dfmp_merge
(
    input  logic             clk,
    input  logic             rst_n,
    input  dfmp_pkg::ctrl_t  ctrl,
    input  dfmp_pkg::comp3_t proj [0:dfmp_pkg::NUM_PARTS-1],
    input  dfmp_pkg::comp3_t orig [0:dfmp_pkg::NUM_PARTS-1],
    output logic             done,
    output logic             zero_wave,
    output dfmp_pkg::comp3_t out  [0:dfmp_pkg::NUM_PARTS-1]
);
    import dfmp_pkg::*;

    logic   done_reg;
    logic   zero_reg;
    comp3_t out_reg  [0:NUM_PARTS-1];
    comp3_t out_next [0:NUM_PARTS-1];

    always_comb
    begin
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_next[p][i] = ctrl.zero ? orig[p][i] : proj[p][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= ctrl.zero;
        out_reg  <= out_next;
    end

    assign done      = done_reg;
    assign zero_wave = zero_reg;
    assign out       = out_reg;

endmodule

/* design/divergence_free_mode_projection.sv */
// ----------------------------------------------------------------------------
// divergence_free_mode_projection
// Removes the component of a complex 3-vector along an integer wave vector.
// ----------------------------------------------------------------------------
// One Fourier mode is taken on every clock with start high; busy never rises,
// and the projected vector appears on the out ports with done high for a
// single cycle, in request order. The receiver cannot stall. The quotient
// of k.v by |k|^2 comes out of a 10-stage pipeline that resolves 4 bits per
// stage, one copy in each of the real and imaginary lanes, with three stages
// ahead of it (products, dot sum and magnitude) and two after it for the
// correction and saturation, plus the input and output registers.
// ----------------------------------------------------------------------------
`include "divergence_free_mode_projection_assert.svh"

module divergence_free_mode_projection
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dfmp_pkg::wave_t wave_x,
    input  dfmp_pkg::wave_t wave_y,
    input  dfmp_pkg::wave_t wave_z,
    input  dfmp_pkg::comp_t vec0_re,
    input  dfmp_pkg::comp_t vec0_im,
    input  dfmp_pkg::comp_t vec1_re,
    input  dfmp_pkg::comp_t vec1_im,
    input  dfmp_pkg::comp_t vec2_re,
    input  dfmp_pkg::comp_t vec2_im,
    output logic            done,
    output dfmp_pkg::comp_t out0_re,
    output dfmp_pkg::comp_t out0_im,
    output dfmp_pkg::comp_t out1_re,
    output dfmp_pkg::comp_t out1_im,
    output dfmp_pkg::comp_t out2_re,
    output dfmp_pkg::comp_t out2_im,
    output logic            zero_wave
);
    import dfmp_pkg::*;

    wave3_t k_next;
    wave3_t k_reg;
    norm_t  n_next;
    norm_t  n_reg;
    logic   zero_reg;
    logic   s1_valid_reg;
    comp3_t v_next [0:NUM_PARTS-1];
    comp3_t v_reg  [0:NUM_PARTS-1];
    ctrl_t  ctrl_reg [0:LANE_LAT-1];
    comp3_t proj   [0:NUM_PARTS-1];
    comp3_t orig   [0:NUM_PARTS-1];
    comp3_t res    [0:NUM_PARTS-1];

    function automatic wave_t clamp_wave(input wave_t w);
        if (w > WAVE_HI)
        begin
            return WAVE_HI;
        end
        else if (w < WAVE_LO)
        begin
            return WAVE_LO;
        end
        else
        begin
            return w;
        end
    endfunction

    function automatic norm_t wave_sq(input wave_t w);
        logic signed [2*WAVE_W-1:0] wx;
        logic signed [2*WAVE_W-1:0] sq;
        wx = (2*WAVE_W)'(w);
        sq = wx * wx;
        return sq[NORM_W-1:0];
    endfunction

    // fully pipelined: a request is taken on any cycle
    assign busy = 1'b0;

    always_comb
    begin
        k_next[0] = clamp_wave(wave_x);
        k_next[1] = clamp_wave(wave_y);
        k_next[2] = clamp_wave(wave_z);
        n_next    = wave_sq(k_next[0]) + wave_sq(k_next[1]) + wave_sq(k_next[2]);
        v_next[0][0] = vec0_re;
        v_next[0][1] = vec1_re;
        v_next[0][2] = vec2_re;
        v_next[1][0] = vec0_im;
        v_next[1][1] = vec1_im;
        v_next[1][2] = vec2_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < LANE_LAT; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            ctrl_reg[0]  <= '{valid: s1_valid_reg, zero: zero_reg};
            for (int i = 1; i < LANE_LAT; i++)
            begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        n_reg    <= n_next;
        zero_reg <= (n_next == '0);
        v_reg    <= v_next;
    end

    for (genvar p = 0; p < NUM_PARTS; p++)
    begin : g_lane
        dfmp_lane u_lane
        (
            .clk  (clk),
            .k    (k_reg),
            .n    (n_reg),
            .v    (v_reg[p]),
            .proj (proj[p]),
            .orig (orig[p])
        );
    end

    dfmp_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_reg[LANE_LAT-1]),
        .proj      (proj),
        .orig      (orig),
        .done      (done),
        .zero_wave (zero_wave),
        .out       (res)
    );

    assign out0_re = res[0][0];
    assign out1_re = res[0][1];
    assign out2_re = res[0][2];
    assign out0_im = res[1][0];
    assign out1_im = res[1][1];
    assign out2_im = res[1][2];

    `DFMP_ASSERT_IMPLY(a_done_has_request, clk, rst_n, done,
        $past(start && !busy, TOTAL_LAT), "result strobe without a matching request")
    `DFMP_ASSERT_IMPLY(a_zero_flag, clk, rst_n, done,
        zero_wave == $past(wave_x == '0 && wave_y == '0 && wave_z == '0, TOTAL_LAT),
        "zero wave flag does not match the request")
    `DFMP_ASSERT_NEVER(a_zero_passthrough, clk, rst_n,
        done && zero_wave && (out0_re != $past(vec0_re, TOTAL_LAT) ||
        out2_im != $past(vec2_im, TOTAL_LAT)),
        "zero wave result does not pass the vector through")

endmodule
